FILE: hw/rtl/udphcb_pkg.sv
// Package: shared types, constants and the ones' complement add for the UDP header builder.
`default_nettype none

package udphcb_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SRC_PORT     = 3'd0;
    localparam logic [2:0] REG_DST_PORT     = 3'd1;
    localparam logic [2:0] REG_SRC_IP       = 3'd2;
    localparam logic [2:0] REG_DST_IP       = 3'd3;
    localparam logic [2:0] REG_CHECKSUM_OFF = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [16:0] COUNT_LIMIT   = 17'd65528;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [15:0] UDP_PROTO     = 16'd17;

    // Checksum sequencer: one term per step, last step index
    localparam int            STEP_W    = 4;
    localparam logic [STEP_W-1:0] STEP_PAD      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SIP_HI   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SIP_LO   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIP_HI   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIP_LO   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PROTO    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PLEN     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SPORT    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DPORT    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_HLEN     = 4'd9;

    // Configuration register set
    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic        checksum_off;
    } cfg_t;

    // Closing record passed from front to back
    typedef struct packed {
        logic [15:0] sum;
        logic [7:0]  hold;
        logic [16:0] count;
        logic        too_large;
    } close_rec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FIN
    } bk_state_t;

    // Ones' complement 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/udphcb_front.sv
// Front: accepts payload words, keeps the running sum and count, pushes a closing record.
`default_nettype none

module udphcb_front
    import udphcb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] payload_byte,
    input  wire logic       byte_valid,
    input  wire logic       last,
    output logic            push,
    output close_rec_t      push_rec,
    input  wire logic       q_full
);

    logic [15:0] sum_reg, sum_next;
    logic [16:0] count_reg, count_next;
    logic [7:0]  hold_reg, hold_next;
    logic        take;
    logic        add_byte;

    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;
    assign add_byte = byte_valid && (count_reg < COUNT_LIMIT);

    // Fold the byte into the running state
    always_comb
    begin
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        if (add_byte)
        begin
            if (!count_reg[0])
            begin
                hold_next = payload_byte;
            end
            else
            begin
                sum_next = oc_add(sum_reg, {hold_reg, payload_byte});
            end
            count_next = count_reg + 17'd1;
        end
    end

    // Closing record carries the state after this word
    assign push               = take && last;
    assign push_rec.sum       = sum_next;
    assign push_rec.hold      = hold_next;
    assign push_rec.count     = count_next;
    assign push_rec.too_large = (count_next >= COUNT_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            hold_reg  <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                sum_reg   <= '0;
                hold_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/udphcb_fifo.sv
// Short queue of closing records between front and back.
`default_nettype none

module udphcb_fifo
    import udphcb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire close_rec_t push_rec,
    input  wire logic       pop,
    output close_rec_t      pop_rec,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    close_rec_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_MAX);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/udphcb_back.sv
// Back: folds pseudo-header and header terms into the sum, one add a cycle, and drives the output.
`default_nettype none

module udphcb_back
    import udphcb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire close_rec_t  rec,
    input  wire logic        q_empty,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      header_word,
    output logic             too_large
);

    bk_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [15:0]       acc_reg;
    logic [15:0]       len_reg;
    logic [15:0]       pad_reg;
    logic              big_reg;
    logic              out_valid_reg;
    logic [63:0]       header_word_reg;
    logic              too_large_reg;

    logic              out_free;
    logic              load;
    logic              do_step;
    logic              out_load;
    logic [15:0]       term;
    logic [15:0]       csum;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = rec.too_large ? BK_FIN : BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (step_reg == STEP_HLEN)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        load     = 1'b0;
        do_step  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                load = !q_empty;
            end
            BK_RUN:
            begin
                do_step = 1'b1;
            end
            BK_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign pop = load;

    // Term for the current step
    always_comb
    begin
        case (step_reg)
            STEP_PAD:    term = pad_reg;
            STEP_SIP_HI: term = cfg.src_ip[31:16];
            STEP_SIP_LO: term = cfg.src_ip[15:0];
            STEP_DIP_HI: term = cfg.dst_ip[31:16];
            STEP_DIP_LO: term = cfg.dst_ip[15:0];
            STEP_PROTO:  term = UDP_PROTO;
            STEP_PLEN:   term = len_reg;
            STEP_SPORT:  term = cfg.src_port;
            STEP_DPORT:  term = cfg.dst_port;
            STEP_HLEN:   term = len_reg;
            default:     term = '0;
        endcase
    end

    // Final checksum; zero goes out as all ones, and zero is sent when checksum_off is set
    always_comb
    begin
        csum = ~acc_reg;
        if (csum == '0)
        begin
            csum = 16'hFFFF;
        end
        if (cfg.checksum_off)
        begin
            csum = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg <= STEP_PAD;
            acc_reg  <= rec.sum;
            len_reg  <= rec.count[15:0] + UDP_HDR_BYTES;
            pad_reg  <= rec.count[0] ? {rec.hold, 8'd0} : 16'd0;
            big_reg  <= rec.too_large;
        end
        else if (do_step)
        begin
            step_reg <= step_reg + 1'b1;
            acc_reg  <= oc_add(acc_reg, term);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (big_reg)
            begin
                header_word_reg <= '0;
            end
            else
            begin
                header_word_reg <= {cfg.src_port, cfg.dst_port, len_reg, csum};
            end
            too_large_reg <= big_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign header_word = header_word_reg;
    assign too_large   = too_large_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/udp_header_checksum_builder.sv
// Top level: UDP header builder with IPv4 pseudo-header checksum.
//
//   Channel  Direction  Handshake          Word
//   in       sink       in_valid/in_stall  payload_byte, byte_valid, last
//   out      source     out_valid/out_stall header_word, too_large
//   cfg      sink       cfg_wr_en          cfg_index, cfg_wdata
//
// Payload words are taken one per clock while in_stall is low; every second valid byte costs one
// ones' complement add in the front. A closing word queues a record; the back loads it, adds
// ten terms (odd-length pad, pseudo-header, header) one per step through one shared adder and
// loads the output; an oversize datagram skips the adds. The back takes its next record only
// after it has loaded the output for the last one; faster closing words fill the queue and
// raise in_stall.
// rst_n clears the running state, queue pointers, sequencer state, output valid and configuration registers.
// out_stall holds the output register; the back finishes its sum and waits until it frees.
`default_nettype none

module udp_header_checksum_builder
    import udphcb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            payload_byte,
    input  wire logic                  byte_valid,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [63:0]                header_word,
    output logic                       too_large
);

    cfg_t       cfg_reg;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    close_rec_t push_rec;
    close_rec_t pop_rec;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SRC_PORT:     cfg_reg.src_port     <= cfg_wdata[15:0];
                REG_DST_PORT:     cfg_reg.dst_port     <= cfg_wdata[15:0];
                REG_SRC_IP:       cfg_reg.src_ip       <= cfg_wdata;
                REG_DST_IP:       cfg_reg.dst_ip       <= cfg_wdata;
                REG_CHECKSUM_OFF: cfg_reg.checksum_off <= cfg_wdata[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    udphcb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .last         (last),
        .push         (push),
        .push_rec     (push_rec),
        .q_full       (q_full)
    );

    udphcb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    udphcb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .rec         (pop_rec),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .header_word (header_word),
        .too_large   (too_large)
    );

endmodule

`default_nettype wire

FILE: tb/udp_header_checksum_builder_test.sv
// Testbench: drives payload bytes and checks each UDP header against a predicted header.
`timescale 1ns / 1ps

// Predicts UDP headers from accepted payload words and checks the block's header words
class udp_header_scoreboard;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic        checksum_off;

    // running payload state
    logic [15:0] word_sum;
    logic [16:0] byte_total;
    logic [7:0]  high_byte;

    logic [63:0] header_q[$];
    logic        too_large_q[$];
    int          errors;

    function new();
        src_port     = '0;
        dst_port     = '0;
        src_ip       = '0;
        dst_ip       = '0;
        checksum_off = 1'b0;
        errors       = 0;
        clear_payload();
    endfunction

    function void clear_payload();
        word_sum   = '0;
        byte_total = '0;
        high_byte  = '0;
    endfunction

    // Append one expected result
    function void expect_word(input logic [63:0] hdr, input logic tl);
        header_q    = {header_q, hdr};
        too_large_q = {too_large_q, tl};
    endfunction

    // 16-bit add with end-around carry
    static function logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            udphcb_pkg::REG_SRC_PORT:     src_port = data[15:0];
            udphcb_pkg::REG_DST_PORT:     dst_port = data[15:0];
            udphcb_pkg::REG_SRC_IP:       src_ip = data;
            udphcb_pkg::REG_DST_IP:       dst_ip = data;
            udphcb_pkg::REG_CHECKSUM_OFF: checksum_off = data[0];
            default: ;
        endcase
    endfunction

    // Called for every accepted input word
    function void note_word(input logic [7:0] b, input logic bv, input logic lst);
        logic [15:0] s;
        logic [15:0] len;
        logic [15:0] csum;
        if (bv && byte_total < udphcb_pkg::COUNT_LIMIT)
        begin
            if (!byte_total[0])
                high_byte = b;
            else
                word_sum = ones_add(word_sum, {high_byte, b});
            byte_total = byte_total + 17'd1;
        end
        if (!lst)
            return;
        if (byte_total >= udphcb_pkg::COUNT_LIMIT)
        begin
            expect_word(64'd0, 1'b1);
        end
        else
        begin
            len  = byte_total[15:0] + udphcb_pkg::UDP_HDR_BYTES;
            csum = 16'h0000;
            if (!checksum_off)
            begin
                s = word_sum;
                // odd length: last byte padded with a zero low byte
                if (byte_total[0])
                    s = ones_add(s, {high_byte, 8'h00});
                s = ones_add(s, src_ip[31:16]);
                s = ones_add(s, src_ip[15:0]);
                s = ones_add(s, dst_ip[31:16]);
                s = ones_add(s, dst_ip[15:0]);
                s = ones_add(s, udphcb_pkg::UDP_PROTO);
                s = ones_add(s, len);
                s = ones_add(s, src_port);
                s = ones_add(s, dst_port);
                s = ones_add(s, len);
                csum = ~s;
                // a zero checksum goes out as all ones
                if (csum == 16'h0000)
                    csum = 16'hFFFF;
            end
            expect_word({src_port, dst_port, len, csum}, 1'b0);
        end
        clear_payload();
    endfunction

    // Called for every accepted output word
    function void check_header(input logic [63:0] hdr, input logic tl);
        logic [63:0] want_hdr;
        logic        want_tl;
        if (header_q.size() == 0)
        begin
            $error("unexpected header word %h, too_large %b", hdr, tl);
            errors++;
            return;
        end
        want_hdr = header_q.pop_front();
        want_tl  = too_large_q.pop_front();
        if (hdr !== want_hdr)
        begin
            $error("header_word: expected %h, got %h", want_hdr, hdr);
            errors++;
        end
        if (tl !== want_tl)
        begin
            $error("too_large: expected %b, got %b", want_tl, tl);
            errors++;
        end
    endfunction

    function int pending();
        return header_q.size();
    endfunction
endclass

module udp_header_checksum_builder_test
    import udphcb_pkg::*;
();

    localparam int LIMIT_CYCLES     = 2_000_000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 20;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [7:0]            payload_byte = '0;
    logic                  byte_valid   = 1'b0;
    logic                  last         = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [63:0]           header_word;
    logic                  too_large;

    udp_header_scoreboard sb;
    bit calm       = 1'b0;   // no idling on either side
    bit long_hold  = 1'b0;   // receiver holds off for a long stretch
    int cycles     = 0;
    int items_sent = 0;

    udp_header_checksum_builder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .header_word  (header_word),
        .too_large    (too_large)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Payload length: mostly short datagrams
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 12);
        if (r < 95)
            return $urandom_range(13, 64);
        return $urandom_range(65, 250);
    endfunction

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("udp_header_checksum_builder regression: fail");
            $finish;
        end
    end

    // Monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(payload_byte, byte_valid, last);
            if (out_valid && !out_stall)
                sb.check_header(header_word, too_large);
        end
    end

    // Receiver: random stalls, a long hold on request
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (calm || !rst_n)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one input word and wait until it is taken
    task automatic send_word(input logic [7:0] b, input logic bv, input logic lst);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        payload_byte <= b;
        byte_valid   <= bv;
        last         <= lst;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Write every register; unused upper bits and unused indexes carry junk
    task automatic program_regs(input logic [15:0] sp, input logic [15:0] dp,
                                input logic [31:0] sip, input logic [31:0] dip,
                                input logic off);
        int k;
        for (k = REG_CHECKSUM_OFF + 1; k < (1 << CFG_IDX_W); k++)
            put_reg(CFG_IDX_W'(k), $urandom);
        put_reg(REG_SRC_PORT, {16'($urandom), sp});
        put_reg(REG_DST_PORT, {16'($urandom), dp});
        put_reg(REG_SRC_IP, sip);
        put_reg(REG_DST_IP, dip);
        put_reg(REG_CHECKSUM_OFF, {31'($urandom), off});
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every header has come back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One datagram with random bytes and occasional ignored words
    task automatic send_packet(input int nbytes, input bit close_empty);
        int i;
        for (i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, !close_empty && i == nbytes - 1);
        end
        if (close_empty || nbytes == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Back-to-back short datagrams against a held-off receiver
    task automatic flood();
        int i;
        calm = 1'b1;
        long_hold = 1'b1;
        for (i = 0; i < 30; i++)
            send_packet(i % 2, 1'b0);
        calm = 1'b0;
    endtask

    initial
    begin
        int ph;
        int target;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty datagram whose sum folds to zero: checksum sent as all ones
        program_regs(16'hFFDE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
        drain();

        // All-ones registers: odd, even, empty close, ignored word mid-datagram
        program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        send_word(8'h12, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h34, 1'b1, 1'b1);
        drain();

        // Checksum disabled
        program_regs(16'h1234, 16'h0035, 32'hC0A8_0001, 32'h0A00_0002, 1'b1);
        send_word(8'hDE, 1'b1, 1'b0);
        send_word(8'hAD, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        drain();

        // Random datagrams over several register settings
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
                1: program_regs(16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
                default: program_regs(16'($urandom), 16'($urandom), $urandom, $urandom,
                                      ph == 2 || $urandom_range(0, 3) == 0);
            endcase
            if (ph == 3)
                flood();
            target = items_sent + 110;
            while (items_sent < target)
            begin
                calm = ($urandom_range(0, 6) == 0);
                send_packet(pick_length(), $urandom_range(0, 4) == 0);
            end
            calm = 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("udp_header_checksum_builder regression: pass");
        else
            $display("udp_header_checksum_builder regression: fail");
        $finish;
    end
endmodule
